>>> sv/llfs_pkg.sv
// llfs_pkg: shared types, widths and helpers for the lru line frame store
// no dependencies; used by the interfaces, the frame cam, the top level, the checker and the testbench
`default_nettype none

package llfs_pkg;

	localparam int STORE_DEPTH_DEF = 18;
	localparam int LINE_W          = 10;
	localparam int FRAME_W         = 9;
	localparam int CNT_OUT_W       = 5;
	localparam int MODE_W          = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_TOUCH = 2'd1,
		MODE_FAULT = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// controls from the sequencer to the frame cam
	typedef struct packed {
		logic clear;
		logic load;
	} cam_ctl_t;

	// frame = line / 3 as a multiply by 683 and a shift, exact for 10-bit lines
	function automatic logic [FRAME_W-1:0] frame_of(input logic [LINE_W-1:0] line);
		logic [19:0] prod;
		prod = {10'd0, line} * 20'd683;
		return prod[19:11];
	endfunction

endpackage

`default_nettype wire

>>> sv/llfs_if.sv
// llfs_in_if and llfs_out_if: valid/ready channels for request and result words
// depends on llfs_pkg for field widths
`default_nettype none

interface llfs_in_if;
	logic                             valid;
	logic                             ready;
	logic [llfs_pkg::MODE_W-1:0]      mode;
	logic [llfs_pkg::LINE_W-1:0]      line_index;

	modport source (output valid, output mode, output line_index, input ready);
	modport sink   (input valid, input mode, input line_index, output ready);
endinterface

interface llfs_out_if;
	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic [llfs_pkg::FRAME_W-1:0]     victim_frame;
	logic                             victim_valid;
	logic [llfs_pkg::CNT_OUT_W-1:0]   resident_count;

	modport source (output valid, output hit, output victim_frame, output victim_valid,
		output resident_count, input ready);
	modport sink   (input valid, input hit, input victim_frame, input victim_valid,
		input resident_count, output ready);
endinterface

`default_nettype wire

>>> sv/llfs_ram.sv
// llfs_ram: single-write, single-read synchronous memory holding the recency list
// no package dependency; read data is registered
`default_nettype none

module llfs_ram #(
	parameter int DEPTH = 18,
	parameter int WIDTH = 10
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/llfs_frame_cam.sv
// llfs_frame_cam: records the frames seen during a list scan and keeps the
// frame whose first appearance came last; depends on llfs_pkg
`default_nettype none

module llfs_frame_cam #(
	parameter int DEPTH = llfs_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire llfs_pkg::cam_ctl_t            ctl,
	input  wire logic [$clog2(DEPTH)-1:0]      idx,
	input  wire logic [llfs_pkg::FRAME_W-1:0]  frame,
	output      logic [llfs_pkg::FRAME_W-1:0]  victim
);

	import llfs_pkg::*;

	logic [DEPTH-1:0]   valid_q;
	logic [FRAME_W-1:0] frames_q [DEPTH];
	logic [FRAME_W-1:0] victim_q;
	logic               seen;

	// entries fill in scan order, so every valid entry lies before idx
	always_comb begin
		seen = 1'b0;
		for (int k = 0; k < DEPTH; k++) begin
			if (valid_q[k] && (frames_q[k] == frame)) begin
				seen = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.load) begin
			valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			frames_q[idx] <= frame;
			if (!seen) begin
				victim_q <= frame;
			end
		end
	end

	assign victim = victim_q;

endmodule

`default_nettype wire

>>> sv/lru_line_frame_store.sv
// lru_line_frame_store: move-to-front recency list of lines, frames of three lines
// one item at a time; ready only while idle, and the block goes idle as the result word
// registers. load/touch: prep, then a move pass, one entry moved per cycle, up to the list
// position reached (at most the count plus one, <= STORE_DEPTH). fault: prep, a scan of all
// resident entries, then a prep and a move pass per victim line; no work to do: straight
// to the result. async reset empties the list (count zero); memory contents need no clearing
`default_nettype none

module lru_line_frame_store #(
	parameter int STORE_DEPTH = llfs_pkg::STORE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	llfs_in_if.sink    req,
	llfs_out_if.source rsp
);

	import llfs_pkg::*;

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_MOVE = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic               rsp_valid_q;

	mode_t              mode_q;
	logic [LINE_W-1:0]  line_q;
	logic [CW-1:0]      limit_q;
	logic [1:0]         pass_q;
	logic               scan_q;
	logic               hit_q;
	logic               vvalid_q;
	logic [IW-1:0]      idx_s1;
	logic [LINE_W-1:0]  carry_q;

	logic               rsp_hit_q;
	logic [FRAME_W-1:0] rsp_victim_q;
	logic               rsp_vvalid_q;
	logic [CW-1:0]      rsp_count_q;
	logic [CW+CNT_OUT_W-1:0] count_ext;

	logic               fire;
	logic               out_free;
	logic [LINE_W-1:0]  rd_data;
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic [CW-1:0]      idx_ext;
	logic               scan_last;
	logic               match;
	logic               move_last;
	logic [LINE_W:0]    key;
	logic [LINE_W-1:0]  front;
	logic [FRAME_W-1:0] victim;
	cam_ctl_t           cam_ctl;

	assign fire     = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign idx_ext   = CW'(idx_s1);
	assign scan_last = (idx_ext == count_q - ONE_C);

	// search key: the line itself, or the victim frame's line for this pass
	always_comb begin
		if (mode_q == MODE_FAULT) begin
			key = {2'b00, victim} + {1'b0, victim, 1'b0} + {{(LINE_W-1){1'b0}}, pass_q};
		end else begin
			key = {1'b0, line_q};
		end
	end

	assign front     = line_q + {{(LINE_W-2){1'b0}}, pass_q};
	assign match     = (idx_ext < count_q) && ({1'b0, rd_data} == key);
	assign move_last = match || (idx_ext == limit_q - ONE_C);

	// read ahead one entry while the current one is written back
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_s1 + IW'(1);
		case (state_q)
			ST_PREP: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_SCAN: rd_en = !scan_last;
			ST_MOVE: rd_en = !move_last;
			default: rd_en = 1'b0;
		endcase
	end

	llfs_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (LINE_W)
	) u_llfs_ram (
		.clk   (clk),
		.we    (state_q == ST_MOVE),
		.waddr (idx_s1),
		.wdata (carry_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign cam_ctl.clear = fire;
	assign cam_ctl.load  = (state_q == ST_SCAN);

	llfs_frame_cam #(
		.DEPTH (STORE_DEPTH)
	) u_llfs_frame_cam (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cam_ctl),
		.idx    (idx_s1),
		.frame  (frame_of(rd_data)),
		.victim (victim)
	);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					case (mode_t'(req.mode))
						MODE_LOAD:  state_d = ST_PREP;
						MODE_TOUCH,
						MODE_FAULT: state_d = (count_q != '0) ? ST_PREP : ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_PREP: state_d = scan_q ? ST_SCAN : ST_MOVE;
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_PREP;
				end
			end
			ST_MOVE: begin
				if (move_last) begin
					if ((mode_q == MODE_FAULT) && (pass_q != 2'd2)) begin
						state_d = ST_PREP;
					end else begin
						state_d = ST_DONE;
					end
					// a load of an absent line grows the list up to its limit
					if ((mode_q == MODE_LOAD) && !match) begin
						count_d = limit_q;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if ((state_q == ST_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					mode_q   <= mode_t'(req.mode);
					line_q   <= req.line_index;
					hit_q    <= 1'b0;
					pass_q   <= 2'd0;
					scan_q   <= (mode_t'(req.mode) == MODE_FAULT);
					vvalid_q <= (mode_t'(req.mode) == MODE_FAULT) && (count_q != '0);
					if ((mode_t'(req.mode) == MODE_LOAD) && (count_q < DEPTH_C)) begin
						limit_q <= count_q + ONE_C;
					end else begin
						limit_q <= count_q;
					end
				end
			end
			ST_PREP: begin
				idx_s1  <= '0;
				carry_q <= front;
			end
			ST_SCAN: begin
				if (scan_last) begin
					scan_q <= 1'b0;
				end else begin
					idx_s1 <= idx_s1 + IW'(1);
				end
			end
			ST_MOVE: begin
				if (match && (mode_q != MODE_FAULT)) begin
					hit_q <= 1'b1;
				end
				if (move_last) begin
					pass_q <= pass_q + 2'd1;
				end else begin
					carry_q <= rd_data;
					idx_s1  <= idx_s1 + IW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_hit_q    <= hit_q;
					rsp_victim_q <= vvalid_q ? victim : '0;
					rsp_vvalid_q <= vvalid_q;
					rsp_count_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign count_ext = {{CNT_OUT_W{1'b0}}, rsp_count_q};

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = rsp_hit_q;
	assign rsp.victim_frame   = rsp_victim_q;
	assign rsp.victim_valid   = rsp_vvalid_q;
	assign rsp.resident_count = count_ext[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

>>> sv/llfs_checker.sv
// llfs_checker: port-level properties of the lru line frame store, bound to the top
// depends on llfs_pkg for field widths
`default_nettype none

module llfs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          hit,
	input wire logic [llfs_pkg::FRAME_W-1:0]  victim_frame,
	input wire logic                          victim_valid,
	input wire logic [llfs_pkg::CNT_OUT_W-1:0] resident_count
);

	// one word in flight: the block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is still in work");

	// a stalled result word holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(victim_frame)
			&& $stable(victim_valid) && $stable(resident_count))
		else $error("result word changed while stalled");

	// an eviction never reports a hit
	a_fault_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && victim_valid |-> !hit)
		else $error("hit flagged on an eviction");

	// no eviction, no victim frame; an eviction needs a resident line
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (victim_valid || (victim_frame == '0))
			&& (!victim_valid || (resident_count != '0)))
		else $error("victim frame inconsistent with eviction flag");

endmodule

bind lru_line_frame_store llfs_checker u_llfs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.hit            (rsp.hit),
	.victim_frame   (rsp.victim_frame),
	.victim_valid   (rsp.victim_valid),
	.resident_count (rsp.resident_count)
);

`default_nettype wire

>>> tb/testbench.sv
// testbench for lru_line_frame_store: directed rows then pool-biased random requests,
// every result word checked against its typed row or a recency-list predictor in this file
// depends on llfs_pkg and the llfs_in_if / llfs_out_if interfaces
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import llfs_pkg::*;

	localparam int DEPTH       = STORE_DEPTH_DEF;
	localparam int FRAME_LINES = 3;
	localparam int RAND_WORDS  = 1200;
	localparam int POOL_FRAMES = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 100;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic                 hit;
		logic [FRAME_W-1:0]   victim_frame;
		logic                 victim_valid;
		logic [CNT_OUT_W-1:0] resident_count;
	} status_t;

	typedef struct packed {
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic              typed;
		status_t           want;
	} stim_row_t;

	localparam status_t NO_WANT = '0;
	localparam int N_ROWS = 24;

	// typed rows are those read straight off the behaviour from reset
	stim_row_t stim_rows [N_ROWS] = '{
		'{MODE_FAULT, 10'd0,    1'b1, '{1'b0, 9'd0, 1'b0, 5'd0}},
		'{MODE_NONE,  10'd1023, 1'b1, '{1'b0, 9'd0, 1'b0, 5'd0}},
		'{MODE_TOUCH, 10'd0,    1'b1, '{1'b0, 9'd0, 1'b0, 5'd0}},
		'{MODE_LOAD,  10'd0,    1'b1, '{1'b0, 9'd0, 1'b0, 5'd1}},
		'{MODE_LOAD,  10'd1023, 1'b1, '{1'b0, 9'd0, 1'b0, 5'd2}},
		'{MODE_LOAD,  10'd0,    1'b1, '{1'b1, 9'd0, 1'b0, 5'd2}},
		'{MODE_TOUCH, 10'd1023, 1'b1, '{1'b1, 9'd0, 1'b0, 5'd2}},
		'{MODE_TOUCH, 10'd5,    1'b1, '{1'b0, 9'd0, 1'b0, 5'd2}},
		// top frame goes out, two of its lines absent, new frame wraps past 1023
		'{MODE_FAULT, 10'd1022, 1'b0, NO_WANT},
		'{MODE_NONE,  10'd512,  1'b0, NO_WANT},
		'{MODE_LOAD,  10'd682,  1'b0, NO_WANT},
		'{MODE_LOAD,  10'd341,  1'b0, NO_WANT},
		'{MODE_LOAD,  10'd1,    1'b0, NO_WANT},
		'{MODE_LOAD,  10'd2,    1'b0, NO_WANT},
		'{MODE_LOAD,  10'd3,    1'b0, NO_WANT},
		'{MODE_FAULT, 10'd9,    1'b0, NO_WANT},
		'{MODE_TOUCH, 10'd682,  1'b0, NO_WANT},
		'{MODE_FAULT, 10'd1023, 1'b0, NO_WANT},
		'{MODE_LOAD,  10'd1023, 1'b0, NO_WANT},
		'{MODE_TOUCH, 10'd700,  1'b0, NO_WANT},
		'{MODE_FAULT, 10'd300,  1'b0, NO_WANT},
		'{MODE_NONE,  10'd0,    1'b0, NO_WANT},
		'{MODE_LOAD,  10'd0,    1'b0, NO_WANT},
		'{MODE_FAULT, 10'd0,    1'b0, NO_WANT}
	};

	logic clk;
	logic arst_n;

	llfs_in_if  req_ch ();
	llfs_out_if rsp_ch ();

	lru_line_frame_store i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor copy of the list, most recent first
	logic [LINE_W-1:0] lru_lines [DEPTH];
	int unsigned       lru_fill;

	status_t     status_due [$];
	bit          calm;
	int unsigned cycle_count;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned hits_seen;
	int unsigned evictions_seen;
	int unsigned mismatches;

	logic [FRAME_W-1:0] pool [POOL_FRAMES];

	function automatic int unsigned line_pos(input int unsigned key);
		for (int i = 0; i < lru_fill && i < DEPTH; i++)
			if (lru_lines[i] == key)
				return i + 1;
		return 0;
	endfunction

	function automatic void slide_in(input int unsigned top, input int unsigned key);
		int unsigned j;
		if (top > DEPTH)
			top = DEPTH;
		for (j = top; j > 1; j--)
			lru_lines[j-1] = lru_lines[j-2];
		lru_lines[0] = key[LINE_W-1:0];
	endfunction

	// move to front if present, else push in with the oldest falling off
	function automatic bit bring_forward(input int unsigned key);
		int unsigned pos;
		pos = line_pos(key);
		if (pos != 0) begin
			slide_in(pos, key);
			return 1'b1;
		end
		if (lru_fill > 0)
			slide_in(lru_fill, key);
		return 1'b0;
	endfunction

	// frame whose first appearance in the list comes last
	function automatic int unsigned stalest_frame();
		int unsigned f;
		int unsigned lr;
		bit          seen;
		lr = 0;
		for (int i = 0; i < lru_fill && i < DEPTH; i++) begin
			f = lru_lines[i] / FRAME_LINES;
			seen = 1'b0;
			for (int k = 0; k < i; k++)
				if (lru_lines[k] / FRAME_LINES == f)
					seen = 1'b1;
			if (!seen)
				lr = f;
		end
		return lr;
	endfunction

	function automatic status_t lru_predict(input mode_t m, input logic [LINE_W-1:0] l);
		status_t           r;
		int unsigned       victim;
		logic [LINE_W-1:0] fresh;
		r = '0;
		case (m)
			MODE_LOAD: begin
				if (line_pos(l) != 0) begin
					void'(bring_forward(l));
					r.hit = 1'b1;
				end else begin
					if (lru_fill < DEPTH)
						lru_fill++;
					slide_in(lru_fill, l);
				end
			end
			MODE_TOUCH: begin
				r.hit = bring_forward(l);
			end
			MODE_FAULT: begin
				if (lru_fill > 0) begin
					victim = stalest_frame();
					r.victim_frame = victim[FRAME_W-1:0];
					r.victim_valid = 1'b1;
					// victim lines run past 1023 for the top frame, kept wide on purpose
					for (int i = 0; i < FRAME_LINES; i++) begin
						void'(bring_forward(victim * FRAME_LINES + i));
						fresh = l + i[LINE_W-1:0];
						lru_lines[0] = fresh;
					end
				end
			end
			default: begin
			end
		endcase
		r.resident_count = lru_fill[CNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic send_word(input mode_t m, input logic [LINE_W-1:0] l, input logic typed,
		input status_t want);
		status_t predicted;
		if (!calm && $urandom_range(99) < 10) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while (!calm && $urandom_range(99) < 10)
				@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= m;
		req_ch.line_index <= l;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predicted = lru_predict(m, l);
		status_due.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	// sender holds off until every result word is back
	task automatic drain_wait();
		req_ch.valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [LINE_W-1:0] pick_line();
		logic [LINE_W-1:0] base;
		if ($urandom_range(99) < 80) begin
			base = LINE_W'(pool[$urandom_range(POOL_FRAMES-1)] * FRAME_LINES);
			return base + LINE_W'($urandom_range(FRAME_LINES-1));
		end
		return LINE_W'($urandom_range(1023));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d result words outstanding",
			cycle_count, status_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: check accepted words, then choose ready for the next edge
	always @(posedge clk) begin
		status_t got;
		status_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.hit            = rsp_ch.hit;
			got.victim_frame   = rsp_ch.victim_frame;
			got.victim_valid   = rsp_ch.victim_valid;
			got.resident_count = rsp_ch.resident_count;
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result word: hit=%0d victim=%0d/%0d count=%0d",
						got.hit, got.victim_frame, got.victim_valid, got.resident_count);
			end else begin
				want = status_due.pop_front();
				words_checked++;
				if (got.hit)
					hits_seen++;
				if (got.victim_valid)
					evictions_seen++;
				if (got.hit !== want.hit || got.victim_frame !== want.victim_frame ||
					got.victim_valid !== want.victim_valid ||
					got.resident_count !== want.resident_count) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display(
"mismatch on result %0d: expected hit=%0d victim=%0d/%0d count=%0d, got %0d %0d/%0d %0d",
							words_checked, want.hit, want.victim_frame, want.victim_valid,
							want.resident_count, got.hit, got.victim_frame,
							got.victim_valid, got.resident_count);
				end
			end
		end
		rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
	end

	initial begin
		mode_t             m;
		logic [LINE_W-1:0] l;
		int unsigned       roll;

		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= MODE_LOAD;
		req_ch.line_index <= '0;
		calm           = 1'b0;
		words_sent     = 0;
		lru_fill       = 0;
		for (int i = 0; i < DEPTH; i++)
			lru_lines[i] = '0;
		for (int i = 0; i < POOL_FRAMES; i++)
			pool[i] = FRAME_W'($urandom_range(341));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			send_word(stim_rows[r].mode, stim_rows[r].line, stim_rows[r].typed,
				stim_rows[r].want);
		drain_wait();

		for (int n = 0; n < RAND_WORDS; n++) begin
			calm = (n >= 500 && n < 700);
			if (n == 400 || n == 900)
				drain_wait();
			// working set of frames drifts slowly so hits and evictions both occur
			if ($urandom_range(99) < 5)
				pool[$urandom_range(POOL_FRAMES-1)] = FRAME_W'($urandom_range(341));
			roll = $urandom_range(99);
			if (roll < 40)
				m = MODE_LOAD;
			else if (roll < 75)
				m = MODE_TOUCH;
			else if (roll < 95)
				m = MODE_FAULT;
			else
				m = MODE_NONE;
			if (m == MODE_FAULT && $urandom_range(99) < 60)
				l = LINE_W'($urandom_range(341) * FRAME_LINES);
			else
				l = pick_line();
			send_word(m, l, 1'b0, NO_WANT);
		end
		calm = 1'b0;
		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d request words (load, touch, fault, unused mode)",
			words_sent);
		$display("%0d result words checked, %0d hits, %0d frames evicted, %0d outstanding",
			words_checked, hits_seen, evictions_seen, status_due.size());
		if (mismatches == 0 && status_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
